@@ hdl/rtf_pkg.sv @@
package rtf_pkg;

   localparam logic [7:0] ByteBel = 8'h07;
   localparam logic [7:0] ByteLf  = 8'h0A;
   localparam logic [7:0] ByteCr  = 8'h0D;
   localparam logic [7:0] ByteEsc = 8'h1B;
   localparam logic [7:0] ByteA   = 8'h61;
   localparam logic [7:0] ByteLs0 = 8'hE2;
   localparam logic [7:0] ByteLs1 = 8'h80;
   localparam logic [7:0] ByteLs2 = 8'hA8;
   localparam logic [7:0] ByteBm0 = 8'hEF;
   localparam logic [7:0] ByteBm1 = 8'hBB;
   localparam logic [7:0] ByteBm2 = 8'hBF;
   localparam logic [7:0] ByteC2  = 8'hC2;
   localparam logic [7:0] ByteSos = 8'h98;
   localparam logic [7:0] ByteSt  = 8'h9C;

   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } rtf_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       message_end;
      logic       run_last;
   } rtf_rsp_type;

   // One accepted transaction after classification: up to three output bytes.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
   } rtf_work_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic [7:0]      held_first;
      logic [7:0]      held_second;
      logic [1:0]      held_count;
   } rtf_scan_type;

   // Scan the held bytes plus the new byte; at most three scan steps are needed.
   function automatic rtf_scan_type rtf_scan(input logic [1:0] held_count,
                                             input logic [7:0] held_first,
                                             input logic [7:0] held_second,
                                             input logic [7:0] in_byte,
                                             input logic       last);
      logic [4:0][7:0] buf_b;
      logic [3:0][7:0] obuf;
      logic [2:0]      n;
      logic [2:0]      p;
      logic [2:0]      rem;
      logic [2:0]      k;
      logic            done;
      logic            hold;
      logic            matched;
      logic [7:0]      c;
      logic [7:0]      b1;
      logic [7:0]      b2;
      rtf_scan_type    r;
      buf_b = '0;
      obuf  = '0;
      r     = '0;
      k     = 3'd0;
      p     = 3'd0;
      done  = 1'b0;
      case (held_count)
         2'd0: begin
            buf_b[0] = in_byte;
            n = 3'd1;
         end
         2'd1: begin
            buf_b[0] = held_first;
            buf_b[1] = in_byte;
            n = 3'd2;
         end
         default: begin
            buf_b[0] = held_first;
            buf_b[1] = held_second;
            buf_b[2] = in_byte;
            n = 3'd3;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         if (!done && (p < n)) begin
            rem     = n - p;
            c       = buf_b[p];
            b1      = buf_b[p + 3'd1];
            b2      = buf_b[p + 3'd2];
            hold    = 1'b0;
            matched = 1'b0;
            case (c)
               ByteBel: begin
                  matched = 1'b1;
                  p = p + 3'd1;
               end
               ByteLs0: begin
                  if ((rem >= 3'd3) && (b1 == ByteLs1) && (b2 == ByteLs2)) begin
                     matched = 1'b1;
                     obuf[k[1:0]]        = ByteCr;
                     obuf[k[1:0] + 2'd1] = ByteLf;
                     k = k + 3'd2;
                     p = p + 3'd3;
                  end else begin
                     hold = (rem == 3'd1) || ((rem == 3'd2) && (b1 == ByteLs1));
                  end
               end
               ByteBm0: begin
                  if ((rem >= 3'd3) && (b1 == ByteBm1) && (b2 == ByteBm2)) begin
                     matched = 1'b1;
                     p = p + 3'd3;
                  end else begin
                     hold = (rem == 3'd1) || ((rem == 3'd2) && (b1 == ByteBm1));
                  end
               end
               ByteEsc: begin
                  if ((rem >= 3'd2) && (b1 == ByteA)) begin
                     matched = 1'b1;
                     p = p + 3'd2;
                  end else begin
                     hold = (rem == 3'd1);
                  end
               end
               ByteC2: begin
                  if ((rem >= 3'd2) && ((b1 == ByteSos) || (b1 == ByteSt))) begin
                     matched = 1'b1;
                     p = p + 3'd2;
                  end else begin
                     hold = (rem == 3'd1);
                  end
               end
               default: begin
                  hold = 1'b0;
               end
            endcase
            if (!matched) begin
               if (hold && !last) begin
                  r.held_first  = c;
                  r.held_second = (rem >= 3'd2) ? b1 : 8'h00;
                  r.held_count  = rem[1:0];
                  done = 1'b1;
               end else begin
                  obuf[k[1:0]] = c;
                  k = k + 3'd1;
                  p = p + 3'd1;
               end
            end
         end
      end
      r.bytes = obuf[2:0];
      r.count = k[1:0];
      return r;
   endfunction

endpackage

@@ hdl/rtf_front.sv @@
module rtf_front import rtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rtf_req_type  req_data,
   input  logic         queue_full,
   output logic         push,
   output rtf_work_type push_data
);

   logic [7:0]   held_first_ff;
   logic [7:0]   held_second_ff;
   logic [1:0]   held_count_ff;
   logic [7:0]   held_first_in;
   logic [7:0]   held_second_in;
   logic [1:0]   held_count_in;
   logic         accept;
   rtf_scan_type scan;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      scan = rtf_scan(held_count_ff, held_first_ff, held_second_ff,
                      req_data.in_byte, req_data.in_last);
   end

   assign push_data.bytes = scan.bytes;
   assign push_data.count = scan.count;
   assign push_data.last  = req_data.in_last;
   // Skip the queue when a transaction only holds or drops bytes and is not the last.
   assign push = accept && ((scan.count != 2'd0) || req_data.in_last);

   always_comb begin
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      held_count_in  = held_count_ff;
      if (accept) begin
         held_first_in  = scan.held_first;
         held_second_in = scan.held_second;
         held_count_in  = scan.held_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         held_count_ff  <= 2'd0;
      end else begin
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         held_count_ff  <= held_count_in;
      end
   end

endmodule

@@ hdl/rtf_queue.sv @@
module rtf_queue import rtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rtf_work_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output rtf_work_type head
);

   rtf_work_type                mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]     wr_ptr_ff;
   logic [QueuePtrBits-1:0]     rd_ptr_ff;
   logic [QueuePtrBits:0]       count_ff;
   logic [QueuePtrBits-1:0]     wr_ptr_in;
   logic [QueuePtrBits-1:0]     rd_ptr_in;
   logic [QueuePtrBits:0]       count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (count_ff == (QueuePtrBits + 1)'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/rtf_back.sv @@
module rtf_back import rtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   input  rtf_work_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rtf_rsp_type  rsp_data
);

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rtf_rsp_type rsp_data_ff;
   rtf_rsp_type rsp_data_in;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   logic [1:0]  final_idx;
   logic        out_free;
   logic        issue;
   logic        is_final;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = !queue_empty && out_free;
   // A bare end marker counts as one result.
   assign final_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
   assign is_final  = (idx_ff == final_idx);
   assign pop       = issue && is_final;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (out_free) begin
         rsp_valid_in = issue;
      end
      if (issue) begin
         rsp_data_in.has_byte    = (head.count != 2'd0);
         rsp_data_in.out_byte    = (head.count != 2'd0) ? head.bytes[idx_ff] : 8'h00;
         rsp_data_in.run_last    = is_final;
         rsp_data_in.message_end = is_final && head.last;
         idx_in = is_final ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/rtt_text_control_filter.sv @@
// Path: the first result of a transaction is registered in the queue and then in the
// output register, with no wait when the queue is empty and the output is free.
// Throughput: one transaction per cycle while the queue is not full; the output register
// drains one result per cycle while rsp_stall is low, and the four-entry queue between
// classification and output absorbs bursts of transactions with two or three results.
// Reset: synchronous; clears held bytes, queue and output valid.
module rtt_text_control_filter import rtf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rtf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rtf_rsp_type rsp_data
);

   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;
   rtf_work_type push_data;
   rtf_work_type head;

   rtf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   rtf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   rtf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
